// ----- rtl/core/dat_pkg.sv -----
// ----------------------------------------------------------------------------
// dat_pkg: shared types and constants for the torsion angle pipeline
// Widths of the vector stages, the arctangent table and the stage payloads.
// ----------------------------------------------------------------------------
package dat_pkg;

    localparam int COORD_W = 24;
    localparam int OUT_W = 16;
    localparam int COORD_FRAC_BITS = 16;
    localparam int ANGLE_ITERATIONS = 16;
    localparam int TABLE_LEN = 24;
    localparam int XY_W = 34;
    localparam int Z_W = 34;
    localparam int SQ_STEPS = 32;

    localparam logic [Z_W-1:0] HALF_PI_Q30 = 34'd1686629713;
    localparam logic [Z_W-1:0] PI_Q30 = 34'd3373259426;
    localparam logic [OUT_W-1:0] PI_Q13 = 16'd25736;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0] z;
        logic neg1;
        logic neg2;
        logic yzero;
        logic xzero;
        logic allzero;
    } t_cordic;

    function automatic logic [Z_W-1:0] atan_q30(input logic [4:0] i);
        logic [Z_W-1:0] r;
        unique case (i)
            5'd0: r = 34'h03243F6A8;
            5'd1: r = 34'h01DAC6705;
            5'd2: r = 34'h00FADBAFC;
            5'd3: r = 34'h007F56EA6;
            5'd4: r = 34'h003FEAB76;
            5'd5: r = 34'h001FFD55B;
            5'd6: r = 34'h000FFFAAA;
            5'd7: r = 34'h0007FFF55;
            5'd8: r = 34'h0003FFFEA;
            5'd9: r = 34'h0001FFFFD;
            5'd10: r = 34'h0000FFFFF;
            5'd11: r = 34'h00007FFFF;
            5'd12: r = 34'h00003FFFF;
            5'd13: r = 34'h00001FFFF;
            5'd14: r = 34'h00000FFFF;
            5'd15: r = 34'h000007FFF;
            5'd16: r = 34'h000003FFF;
            5'd17: r = 34'h000001FFF;
            5'd18: r = 34'h000000FFF;
            5'd19: r = 34'h0000007FF;
            5'd20: r = 34'h0000003FF;
            5'd21: r = 34'h0000001FF;
            5'd22: r = 34'h0000000FF;
            5'd23: r = 34'h00000007F;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/dat_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// dat_sqrt_cell: one restoring square root step
// Takes one result bit per cycle while enabled; carries its item's side data along.
// ----------------------------------------------------------------------------
module dat_sqrt_cell #(
    parameter int STEP = 0,
    parameter int SIDE_W = 8
) (
    input  logic i_clk,
    input  logic i_en,
    input  logic [63:0] i_rem,
    input  logic [63:0] i_root,
    input  logic [SIDE_W-1:0] i_side,
    output logic [63:0] o_rem,
    output logic [63:0] o_root,
    output logic [SIDE_W-1:0] o_side
);
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

    logic [63:0] w_trial;
    logic [63:0] n_rem;
    logic [63:0] n_root;
    logic [63:0] r_rem;
    logic [63:0] r_root;
    logic [SIDE_W-1:0] r_side;

    // compare-subtract; the leading-zero skip of the bench predictor gives the same result
    always_comb begin
        w_trial = i_root + BIT;
        if (i_rem >= w_trial) begin
            n_rem = i_rem - w_trial;
            n_root = (i_root >> 1) + BIT;
        end else begin
            n_rem = i_rem;
            n_root = i_root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_root <= n_root;
            r_side <= i_side;
        end
    end

    assign o_rem = r_rem;
    assign o_root = r_root;
    assign o_side = r_side;
endmodule

// ----- rtl/core/dat_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// dat_cordic_cell: one vectoring CORDIC rotation
// Rotates toward the x axis by atan(2^-STEP) and hands the vector on.
// ----------------------------------------------------------------------------
module dat_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic i_clk,
    input  logic i_en,
    input  dat_pkg::t_cordic i_d,
    output dat_pkg::t_cordic o_d
);
    dat_pkg::t_cordic n_d;
    dat_pkg::t_cordic r_d;
    logic signed [dat_pkg::XY_W-1:0] w_xs;
    logic signed [dat_pkg::XY_W-1:0] w_ys;

    always_comb begin
        n_d = i_d;
        w_xs = i_d.x >>> STEP;
        w_ys = i_d.y >>> STEP;
        if (i_d.y > 0) begin
            n_d.x = i_d.x + w_ys;
            n_d.y = i_d.y - w_xs;
            n_d.z = i_d.z + dat_pkg::atan_q30(5'(STEP));
        end else begin
            n_d.x = i_d.x - w_ys;
            n_d.y = i_d.y + w_xs;
            n_d.z = i_d.z - dat_pkg::atan_q30(5'(STEP));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule

// ----- rtl/core/dihedral_angle_four_points.sv -----
// Throughput: one request per cycle; the pipeline advances when the output
// register is empty or being read, and holds every stage otherwise.
// The square root takes one bit per cell over 32 cells, CORDIC one step per cell.
// Reset clears the valid bits of every stage; data registers are not reset.
// ----------------------------------------------------------------------------
// dihedral_angle_four_points: torsion angle of four points
// Vector stages, a square root cell chain and a CORDIC cell chain.
// ----------------------------------------------------------------------------
module dihedral_angle_four_points #(
    parameter int ANGLE_ITERATIONS = dat_pkg::ANGLE_ITERATIONS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  logic signed [23:0] i_a_x,
    input  logic signed [23:0] i_a_y,
    input  logic signed [23:0] i_a_z,
    input  logic signed [23:0] i_b_x,
    input  logic signed [23:0] i_b_y,
    input  logic signed [23:0] i_b_z,
    input  logic signed [23:0] i_c_x,
    input  logic signed [23:0] i_c_y,
    input  logic signed [23:0] i_c_z,
    input  logic signed [23:0] i_d_x,
    input  logic signed [23:0] i_d_y,
    input  logic signed [23:0] i_d_z,
    output logic o_valid,
    input  logic i_ready,
    output logic signed [15:0] o_torsion
);
    localparam int NIT = (ANGLE_ITERATIONS < dat_pkg::TABLE_LEN) ?
                         ANGLE_ITERATIONS : dat_pkg::TABLE_LEN;
    localparam int NST = 6 + dat_pkg::SQ_STEPS + NIT;
    localparam int SIDE_W = 2 * 128;

    logic w_en;
    logic [NST-1:0] r_vld;
    logic r_ovld;
    logic signed [15:0] r_tor;

    // whole pipeline advances together; stalls only when the output is held
    assign w_en = !r_ovld || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_ovld;
    assign o_torsion = r_tor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
            r_ovld <= r_vld[NST-1];
        end
    end

    // stage 1: bond vectors
    logic signed [24:0] r_b1 [3];
    logic signed [24:0] r_b2 [3];
    logic signed [24:0] r_b3 [3];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b1[0] <= 25'(i_b_x) - 25'(i_a_x);
            r_b1[1] <= 25'(i_b_y) - 25'(i_a_y);
            r_b1[2] <= 25'(i_b_z) - 25'(i_a_z);
            r_b2[0] <= 25'(i_c_x) - 25'(i_b_x);
            r_b2[1] <= 25'(i_c_y) - 25'(i_b_y);
            r_b2[2] <= 25'(i_c_z) - 25'(i_b_z);
            r_b3[0] <= 25'(i_d_x) - 25'(i_c_x);
            r_b3[1] <= 25'(i_d_y) - 25'(i_c_y);
            r_b3[2] <= 25'(i_d_z) - 25'(i_c_z);
        end
    end

    // stage 2: products for cross terms and |b2|^2
    logic signed [49:0] r_pc1 [6];
    logic signed [49:0] r_pc2 [6];
    logic signed [49:0] r_sq [3];
    logic signed [24:0] r2_b1 [3];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pc1[0] <= r_b2[1] * r_b3[2]; r_pc1[1] <= r_b2[2] * r_b3[1];
            r_pc1[2] <= r_b2[2] * r_b3[0]; r_pc1[3] <= r_b2[0] * r_b3[2];
            r_pc1[4] <= r_b2[0] * r_b3[1]; r_pc1[5] <= r_b2[1] * r_b3[0];
            r_pc2[0] <= r_b1[1] * r_b2[2]; r_pc2[1] <= r_b1[2] * r_b2[1];
            r_pc2[2] <= r_b1[2] * r_b2[0]; r_pc2[3] <= r_b1[0] * r_b2[2];
            r_pc2[4] <= r_b1[0] * r_b2[1]; r_pc2[5] <= r_b1[1] * r_b2[0];
            for (int k = 0; k < 3; k++) begin
                r_sq[k] <= r_b2[k] * r_b2[k];
                r2_b1[k] <= r_b1[k];
            end
        end
    end

    // stage 3: cross products, squared length
    logic signed [50:0] r_c1 [3];
    logic signed [50:0] r_c2 [3];
    logic signed [24:0] r3_b1 [3];
    logic [63:0] r_len2;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_c1[k] <= 51'(r_pc1[2*k]) - 51'(r_pc1[2*k+1]);
                r_c2[k] <= 51'(r_pc2[2*k]) - 51'(r_pc2[2*k+1]);
                r3_b1[k] <= r2_b1[k];
            end
            r_len2 <= 64'(52'(r_sq[0]) + 52'(r_sq[1]) + 52'(r_sq[2])) << 12;
        end
    end

    // stage 4: partial products, each cross-product operand split at bit 26 (low half unsigned)
    logic signed [49:0] r_q1h [3];
    logic signed [51:0] r_q1l [3];
    logic signed [49:0] r_qhh [3];
    logic signed [51:0] r_qhl [3];
    logic signed [51:0] r_qlh [3];
    logic [51:0] r_qll [3];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_q1h[k] <= r3_b1[k] * $signed(r_c1[k][50:26]);
                r_q1l[k] <= r3_b1[k] * $signed({1'b0, r_c1[k][25:0]});
                r_qhh[k] <= $signed(r_c1[k][50:26]) * $signed(r_c2[k][50:26]);
                r_qhl[k] <= $signed(r_c1[k][50:26]) * $signed({1'b0, r_c2[k][25:0]});
                r_qlh[k] <= $signed({1'b0, r_c1[k][25:0]}) * $signed(r_c2[k][50:26]);
                r_qll[k] <= r_c1[k][25:0] * r_c2[k][25:0];
            end
        end
    end

    // stage 4b: combine partial products into the dot-product terms
    logic signed [76:0] r_t1 [3];
    logic signed [101:0] r_t2 [3];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_t1[k] <= (77'(r_q1h[k]) << 26) + 77'(r_q1l[k]);
                r_t2[k] <= (102'(r_qhh[k]) << 52)
                           + ((102'(r_qhl[k]) + 102'(r_qlh[k])) << 26)
                           + 102'(r_qll[k]);
            end
        end
    end

    // stage 5: dot sums, signs and magnitudes
    logic [78:0] r_d1;
    logic [103:0] r_d2;
    logic r_n1;
    logic r_n2;
    logic signed [78:0] w_s1;
    logic signed [103:0] w_s2;
    always_comb begin
        w_s1 = 79'(r_t1[0]) + 79'(r_t1[1]) + 79'(r_t1[2]);
        w_s2 = 104'(r_t2[0]) + 104'(r_t2[1]) + 104'(r_t2[2]);
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_n1 <= w_s1 < 0;
            r_n2 <= w_s2 < 0;
            r_d1 <= (w_s1 < 0) ? 79'(-w_s1) : 79'(w_s1);
            r_d2 <= (w_s2 < 0) ? 104'(-w_s2) : 104'(w_s2);
        end
    end

    // square root chain runs alongside the dot-product stages
    logic [63:0] w_rem [dat_pkg::SQ_STEPS+1];
    logic [63:0] w_root [dat_pkg::SQ_STEPS+1];
    logic [SIDE_W-1:0] w_side [dat_pkg::SQ_STEPS+1];
    assign w_rem[0] = r_len2;
    assign w_root[0] = '0;
    assign w_side[0] = '0;
    // join d1/d2 into the chain at the cell where their item arrives
    logic [SIDE_W-1:0] w_side_in;
    assign w_side_in = {r_n1, r_n2, 71'd0, r_d1, r_d2};

    genvar g;
    generate
        for (g = 0; g < dat_pkg::SQ_STEPS; g++) begin : g_sq
            dat_sqrt_cell #(.STEP(g), .SIDE_W(SIDE_W)) u_cell (
                .i_clk(i_clk), .i_en(w_en),
                .i_rem(w_rem[g]), .i_root(w_root[g]),
                .i_side(g == 3 ? w_side_in : w_side[g]),
                .o_rem(w_rem[g+1]), .o_root(w_root[g+1]), .o_side(w_side[g+1])
            );
        end
    endgenerate

    logic [78:0] w_e1;
    logic [103:0] w_e2;
    logic w_sn1, w_sn2;
    assign w_sn1 = w_side[dat_pkg::SQ_STEPS][SIDE_W-1];
    assign w_sn2 = w_side[dat_pkg::SQ_STEPS][SIDE_W-2];
    assign w_e1 = w_side[dat_pkg::SQ_STEPS][182:104];
    assign w_e2 = w_side[dat_pkg::SQ_STEPS][103:0];

    // stage A: p1 = d1 * len, split into three partial products
    logic [59:0] r_p0, r_p1;
    logic [57:0] r_p2;
    logic [109:0] r_m2;
    logic r_an1, r_an2;
    logic [32:0] w_len;
    always_comb w_len = w_root[dat_pkg::SQ_STEPS][32:0];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p0 <= 60'(w_e1[26:0]) * 60'(w_len);
            r_p1 <= 60'(w_e1[53:27]) * 60'(w_len);
            r_p2 <= 58'(w_e1[78:54]) * 58'(w_len);
            r_m2 <= {w_e2, 6'd0};
            r_an1 <= w_sn1;
            r_an2 <= w_sn2;
        end
    end

    // stage B: combine the partial products
    logic [111:0] r_m1;
    logic [109:0] r_bm2;
    logic r_bn1, r_bn2;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m1 <= 112'(r_p0) + (112'(r_p1) << 27) + (112'(r_p2) << 54);
            r_bm2 <= r_m2;
            r_bn1 <= r_an1;
            r_bn2 <= r_an2;
        end
    end

    // stage C: find the common shift, normalize to below 2^30
    logic [111:0] w_or;
    logic [6:0] w_bl;
    logic [6:0] w_sh;
    dat_pkg::t_cordic r_c0;
    always_comb begin
        w_or = r_m1 | 112'(r_bm2);
        w_bl = '0;
        for (int k = 0; k < 112; k++) begin
            if (w_or[k]) w_bl = 7'(k + 1);
        end
        w_sh = (w_bl > 7'd30) ? w_bl - 7'd30 : 7'd0;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c0.x <= 34'((112'(r_bm2) >> w_sh) & 112'h3FFFFFFF);
            r_c0.y <= 34'((r_m1 >> w_sh) & 112'h3FFFFFFF);
            r_c0.z <= '0;
            r_c0.neg1 <= r_bn1;
            r_c0.neg2 <= r_bn2;
            r_c0.yzero <= (r_m1 >> w_sh) == '0;
            r_c0.xzero <= (112'(r_bm2) >> w_sh) == '0;
            r_c0.allzero <= (r_m1 == '0) && (r_bm2 == '0);
        end
    end

    dat_pkg::t_cordic w_cd [NIT+1];
    assign w_cd[0] = r_c0;
    generate
        for (g = 0; g < NIT; g++) begin : g_cor
            dat_cordic_cell #(.STEP(g)) u_cell (
                .i_clk(i_clk), .i_en(w_en), .i_d(w_cd[g]), .o_d(w_cd[g+1])
            );
        end
    endgenerate

    // final stage: quadrant fix, round, sign
    dat_pkg::t_cordic w_f;
    logic signed [dat_pkg::Z_W-1:0] w_z;
    logic [dat_pkg::Z_W-1:0] w_mag;
    logic [dat_pkg::Z_W-1:0] w_m13;
    logic [15:0] w_res;
    always_comb begin
        w_f = w_cd[NIT];
        if (w_f.yzero) w_z = '0;
        else if (w_f.xzero) w_z = dat_pkg::HALF_PI_Q30;
        else if (w_f.z < 0) w_z = '0;
        else if (w_f.z > $signed(dat_pkg::HALF_PI_Q30)) w_z = dat_pkg::HALF_PI_Q30;
        else w_z = w_f.z;
        w_mag = w_f.neg2 ? dat_pkg::PI_Q30 - w_z : w_z;
        if (w_f.allzero) w_mag = '0;
        w_m13 = (w_mag + 34'd65536) >> 17;
        if (w_m13 > 34'(dat_pkg::PI_Q13)) w_m13 = 34'(dat_pkg::PI_Q13);
        w_res = w_f.neg1 ? 16'(-w_m13) : 16'(w_m13);
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tor <= w_res;
        end
    end
endmodule

// ----- test/dihedral_angle_four_points_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dihedral_angle_four_points_tb: self-checking bench for the torsion pipeline
// Feeds point quartets through a valid/ready driver and checks every torsion
// against an in-bench fixed-point predictor, under random and forced stalls.
// ----------------------------------------------------------------------------
module dihedral_angle_four_points_tb;

    localparam int COORD_W = dat_pkg::COORD_W;
    localparam int OUT_W = dat_pkg::OUT_W;
    localparam int ANGLE_ITERATIONS = dat_pkg::ANGLE_ITERATIONS;
    localparam longint HALF_PI_Q30 = longint'(dat_pkg::HALF_PI_Q30);
    localparam longint PI_Q30 = longint'(dat_pkg::PI_Q30);
    localparam longint PI_Q13 = longint'(dat_pkg::PI_Q13);

    localparam int N_RANDOM = 1030;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 120;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic signed [COORD_W-1:0] v [12];
    } t_quartet;

    localparam longint ATAN_Q30 [24] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
    };

    logic i_clk;
    logic i_rst_n;
    logic i_valid = 1'b0;
    logic o_ready;
    logic signed [COORD_W-1:0] coord [12] = '{default: '0};
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [OUT_W-1:0] o_torsion;

    t_quartet pending_q [$];
    t_quartet drv_item;
    logic signed [OUT_W-1:0] torsion_q [$];
    int n_errors = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_cycles = 0;
    logic req_taken = 1'b0;
    bit sender_paused = 1'b0;
    bit hold_done = 1'b0;
    int hold_count = 0;

    dihedral_angle_four_points DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_a_x    (coord[0]),
        .i_a_y    (coord[1]),
        .i_a_z    (coord[2]),
        .i_b_x    (coord[3]),
        .i_b_y    (coord[4]),
        .i_b_z    (coord[5]),
        .i_c_x    (coord[6]),
        .i_c_y    (coord[7]),
        .i_c_z    (coord[8]),
        .i_d_x    (coord[9]),
        .i_d_y    (coord[10]),
        .i_d_z    (coord[11]),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_torsion(o_torsion)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic signed [127:0] mul_wide(input longint a, input longint b);
        logic signed [127:0] wa;
        logic signed [127:0] wb;
        wa = 128'(a);
        wb = 128'(b);
        return wa * wb;
    endfunction

    // Torsion in Q3.13 from the exact vector products and a vectoring CORDIC.
    function automatic logic signed [OUT_W-1:0] torsion_of(input t_quartet q);
        longint b1 [3];
        longint b2 [3];
        longint b3 [3];
        longint c1 [3];
        longint c2 [3];
        logic signed [127:0] d1;
        logic signed [127:0] d2;
        logic [127:0] m1;
        logic [127:0] m2;
        logic [127:0] both;
        longint unsigned rem;
        longint unsigned root;
        longint unsigned bitv;
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint mag;
        longint m13;
        int bl;
        int sh;
        bit neg1;
        bit neg2;
        for (int k = 0; k < 3; k++) begin
            b1[k] = longint'(q.v[3+k]) - longint'(q.v[k]);
            b2[k] = longint'(q.v[6+k]) - longint'(q.v[3+k]);
            b3[k] = longint'(q.v[9+k]) - longint'(q.v[6+k]);
        end
        c1[0] = b2[1] * b3[2] - b2[2] * b3[1];
        c1[1] = b2[2] * b3[0] - b2[0] * b3[2];
        c1[2] = b2[0] * b3[1] - b2[1] * b3[0];
        c2[0] = b1[1] * b2[2] - b1[2] * b2[1];
        c2[1] = b1[2] * b2[0] - b1[0] * b2[2];
        c2[2] = b1[0] * b2[1] - b1[1] * b2[0];

        // |b2| with six extra fraction bits
        rem = longint'(b2[0] * b2[0] + b2[1] * b2[1] + b2[2] * b2[2]) << 12;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end

        d1 = mul_wide(b1[0], c1[0]) + mul_wide(b1[1], c1[1]) + mul_wide(b1[2], c1[2]);
        d2 = mul_wide(c1[0], c2[0]) + mul_wide(c1[1], c2[1]) + mul_wide(c1[2], c2[2]);
        neg1 = d1 < 0;
        neg2 = d2 < 0;
        m1 = (neg1 ? -d1 : d1) * {64'd0, root};
        m2 = (neg2 ? -d2 : d2) << 6;

        both = m1 | m2;
        bl = 0;
        for (int k = 0; k < 128; k++)
            if (both[k]) bl = k + 1;
        sh = bl > 30 ? bl - 30 : 0;
        y = longint'(m1 >> sh);
        x = longint'(m2 >> sh);

        if (y == 0) begin
            z = 0;
        end else if (x == 0) begin
            z = HALF_PI_Q30;
        end else begin
            z = 0;
            for (int i = 0; i < ANGLE_ITERATIONS && i < 24; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0) begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ATAN_Q30[i];
                end else begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ATAN_Q30[i];
                end
            end
            if (z < 0) z = 0;
            if (z > HALF_PI_Q30) z = HALF_PI_Q30;
        end
        if (x == 0 && y == 0 && m1 == 0) z = 0;

        mag = neg2 ? PI_Q30 - z : z;
        if (m1 == 0 && m2 == 0) mag = 0;
        m13 = (mag + 65536) >>> 17;
        if (m13 > PI_Q13) m13 = PI_Q13;
        return neg1 ? OUT_W'(-m13) : OUT_W'(m13);
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH result %0d: %s", n_checked, what);
        n_errors++;
    endtask

    function automatic t_quartet make_quartet(input int a, input int b, input int c, input int d,
                                              input int e, input int f, input int g,
                                              input int h, input int i, input int j,
                                              input int k, input int l);
        t_quartet q;
        q.v = '{COORD_W'(a), COORD_W'(b), COORD_W'(c), COORD_W'(d),
                COORD_W'(e), COORD_W'(f), COORD_W'(g), COORD_W'(h),
                COORD_W'(i), COORD_W'(j), COORD_W'(k), COORD_W'(l)};
        return q;
    endfunction

    function automatic t_quartet random_quartet();
        t_quartet q;
        int mode;
        int base;
        int span;
        int idx;
        mode = $urandom_range(0, 9);
        base = $urandom;
        span = 1 << $urandom_range(2, 22);
        for (int k = 0; k < 12; k++) begin
            unique case (mode)
                0, 1: q.v[k] = COORD_W'($urandom);
                // local geometry around one spot, the usual molecular case
                2, 3, 4, 5: q.v[k] = COORD_W'(base[23:0] + $urandom_range(0, span) - span / 2);
                // coplanar points: shared z
                6, 7: q.v[k] = (k % 3 == 2) ? base[23:0]
                                            : COORD_W'($urandom_range(0, span) - span / 2);
                // points on one line, step scaled by point index (mode 9 then nudges one coordinate)
                default: q.v[k] = COORD_W'((k / 3) * ((base >> (4 * (k % 3))) & 16'hFFF));
            endcase
        end
        if (mode == 9) begin
            idx = $urandom_range(0, 11);
            q.v[idx] = COORD_W'(q.v[idx] + $urandom_range(0, 3));
        end
        return q;
    endfunction

    // Sender: hold the request until accepted, idle at random outside a no-idle window, pause once.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || req_taken)) begin
            if (n_sent == 600 && !sender_paused) begin
                i_valid <= 1'b0;
                if (torsion_q.size() == 0 && !(i_valid && !req_taken)) sender_paused <= 1'b1;
            end else if (pending_q.size() != 0
                         && ((n_sent >= 800 && n_sent < 950) || $urandom_range(0, 99) >= 35)) begin
                drv_item = pending_q.pop_front();
                coord <= drv_item.v;
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, one long hold-off, a no-stall window.
    always @(negedge i_clk) begin
        if (n_checked >= 200 && !hold_done) begin
            i_ready <= 1'b0;
            hold_count <= hold_count + 1;
            if (hold_count >= HOLD_CYCLES) hold_done <= 1'b1;
        end else if (n_checked >= 700 && n_checked < 850) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= $urandom_range(0, 99) >= 35;
        end
    end

    always @(posedge i_clk) begin
        req_taken <= i_rst_n && i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready) begin
            t_quartet q;
            q.v = coord;
            torsion_q.push_back(torsion_of(q));
            n_sent <= n_sent + 1;
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (torsion_q.size() == 0) begin
                report_mismatch($sformatf("torsion %0d with no request outstanding", o_torsion));
            end else begin
                logic signed [OUT_W-1:0] want;
                want = torsion_q.pop_front();
                if (o_torsion !== want)
                    report_mismatch($sformatf("torsion %0d, predicted %0d", o_torsion, want));
            end
            n_checked <= n_checked + 1;
        end
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", n_cycles);
            $display("dihedral_angle_four_points_tb NOT OK");
            $finish;
        end
    end

    initial begin
        localparam int P = 8388607;
        localparam int M = -8388608;
        localparam int U = 65536;
        i_rst_n = 1'b0;

        // field extremes and alternating bit patterns
        pending_q.push_back(make_quartet(P, P, P, P, P, P, P, P, P, P, P, P));
        pending_q.push_back(make_quartet(M, M, M, M, M, M, M, M, M, M, M, M));
        pending_q.push_back(make_quartet(M, M, M, P, P, P, M, M, M, P, P, P));
        pending_q.push_back(make_quartet(M, P, M, P, M, P, P, M, P, M, P, M));
        pending_q.push_back(make_quartet(M, 0, 0, P, 0, 0, P, P, 0, P, P, P));
        pending_q.push_back(make_quartet(P, M, 0, 0, 0, 0, 0, 0, P, M, P, M));
        pending_q.push_back(make_quartet(24'h555555, 24'hAAAAAA, 24'h555555,
                                         24'hAAAAAA, 24'h555555, 24'hAAAAAA,
                                         24'h555555, 24'h555555, 24'hAAAAAA,
                                         24'hAAAAAA, 24'hAAAAAA, 24'h555555));
        // all points equal, and collinear points: torsion zero
        pending_q.push_back(make_quartet(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_q.push_back(make_quartet(0, 0, 0, U, U, U, 2*U, 2*U, 2*U, 3*U, 3*U, 3*U));
        // coincident middle points: zero b2
        pending_q.push_back(make_quartet(0, U, 0, 0, 0, 0, 0, 0, 0, U, 0, U));
        // planar trans: exactly pi; planar cis: zero
        pending_q.push_back(make_quartet(0, U, 0, 0, 0, 0, U, 0, 0, U, -U, 0));
        pending_q.push_back(make_quartet(0, U, 0, 0, 0, 0, U, 0, 0, U, U, 0));
        // right angles of both signs, near-pi of both signs, and three more angles
        pending_q.push_back(make_quartet(0, U, 0, 0, 0, 0, U, 0, 0, U, 0, U));
        pending_q.push_back(make_quartet(0, U, 0, 0, 0, 0, U, 0, 0, U, 0, -U));
        pending_q.push_back(make_quartet(0, U, 0, 0, 0, 0, U, 0, 0, U, -U, 1));
        pending_q.push_back(make_quartet(0, U, 0, 0, 0, 0, U, 0, 0, U, -U, -1));
        pending_q.push_back(make_quartet(0, U, 0, 0, 0, 0, U, 0, 0, U, -U, U));
        pending_q.push_back(make_quartet(1, 0, 0, 0, 0, 0, 0, 1, 0, 0, 1, 1));
        pending_q.push_back(make_quartet(-1, -1, -1, 0, 0, 0, 1, 0, 0, 1, 1, -1));
        for (int n = 0; n < N_RANDOM; n++) pending_q.push_back(random_quartet());

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (pending_q.size() == 0);
        @(posedge i_clk);
        while (i_valid || torsion_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d quartets sent, %0d torsions checked: extremes, collinear and planar",
                 n_sent, n_checked);
        $display("cases, random geometry, a full-pipeline stall and a sender pause");
        if (n_errors == 0) begin
            $display("dihedral_angle_four_points_tb OK");
        end else begin
            $display("dihedral_angle_four_points_tb NOT OK");
        end
        $finish;
    end

endmodule
